### sv/fcp_pkg.sv
// Shared types, codes and default sizes for the flash command planner.
package fcp_pkg;

    // Default geometry (bytes); all sizes are powers of two
    localparam int unsigned PAGE_BYTES_DEF        = 256;
    localparam int unsigned SECTOR_BYTES_DEF      = 4096;
    localparam int unsigned BLOCK_BYTES_DEF       = 65536;
    localparam int unsigned SMALL_BLOCK_BYTES_DEF = 32768;
    localparam int unsigned ADDR_BITS_DEF         = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_BLOCK_ONLY   = 2'd1;
    localparam logic [1:0] CFG_SMALL_BLOCKS = 2'd2;

    localparam logic [24:0] DEVICE_SIZE_RST = 25'd8388608;

    // Request modes
    localparam logic [1:0] MODE_ERASE = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;

    // Command kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PROG   = 3'd1;
    localparam logic [2:0] KIND_SECTOR = 3'd2;
    localparam logic [2:0] KIND_BLOCK  = 3'd3;
    localparam logic [2:0] KIND_CHIP   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] address;
        logic [24:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  cmd_kind;
        logic [23:0] cmd_address;
        logic [8:0]  cmd_bytes;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [24:0] device_size;
        logic        block_only;
        logic        small_blocks;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic        is_write;
        logic [24:0] cur_addr;
        logic [24:0] bytes_left;
    } plan_state_t;

endpackage

### sv/fcp_cfg_regs.sv
// Configuration register bank of the flash command planner.
module fcp_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [24:0]        cfg_wdata,
    output fcp_pkg::cfg_t      cfg
);
    import fcp_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // Decode the write into the addressed register; other indexes are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEVICE_SIZE:  cfg_next.device_size  = cfg_wdata;
                CFG_BLOCK_ONLY:   cfg_next.block_only   = cfg_wdata[0];
                CFG_SMALL_BLOCKS: cfg_next.small_blocks = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_size  <= DEVICE_SIZE_RST;
            cfg_reg.block_only   <= 1'b0;
            cfg_reg.small_blocks <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/fcp_step.sv
// Single-pass planning logic: one request in, next plan state and one result out.
module fcp_step #(
    parameter int unsigned PAGE_BYTES        = fcp_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES      = fcp_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES       = fcp_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned SMALL_BLOCK_BYTES = fcp_pkg::SMALL_BLOCK_BYTES_DEF,
    parameter int unsigned ADDR_BITS         = fcp_pkg::ADDR_BITS_DEF
) (
    input  fcp_pkg::cfg_t        cfg,
    input  fcp_pkg::plan_state_t state,
    input  fcp_pkg::req_t        req,
    output fcp_pkg::plan_state_t state_next,
    output fcp_pkg::rsp_t        rsp
);
    import fcp_pkg::*;

    // Sizes are powers of two, so modulo is a mask
    localparam logic [24:0] PAGE_SIZE   = 25'(PAGE_BYTES);
    localparam logic [24:0] PAGE_MASK   = 25'(PAGE_BYTES - 1);
    localparam logic [24:0] SECTOR_SIZE = 25'(SECTOR_BYTES);
    localparam logic [24:0] SECTOR_MASK = 25'(SECTOR_BYTES - 1);
    localparam logic [24:0] BLK_SIZE    = 25'(BLOCK_BYTES);
    localparam logic [24:0] SBLK_SIZE   = 25'(SMALL_BLOCK_BYTES);
    localparam logic [23:0] ADDR_MASK   = 24'((64'd1 << ADDR_BITS) - 64'd1);

    logic [24:0] blk_size;
    logic [24:0] blk_mask;
    logic [24:0] unit_mask;
    logic        misaligned;
    logic [25:0] end_addr;
    logic        in_range;
    logic        chip_erase;
    logic [24:0] room;
    logic [24:0] chunk;
    logic [24:0] erase_step;
    logic [24:0] step;
    logic        use_block;
    logic        done;

    // Erase geometry from the current configuration
    assign blk_size  = cfg.small_blocks ? SBLK_SIZE : BLK_SIZE;
    assign blk_mask  = blk_size - 25'd1;
    assign unit_mask = cfg.block_only ? blk_mask : SECTOR_MASK;

    // Start-request checks
    assign misaligned = ((req.length & unit_mask) != '0) ||
                        (({1'b0, req.address} & unit_mask) != '0);
    assign end_addr   = 26'(req.address) + 26'(req.length);
    assign in_range   = (req.length <= cfg.device_size) &&
                        ({1'b0, req.address} <= cfg.device_size) &&
                        (end_addr <= {1'b0, cfg.device_size});
    assign chip_erase = (req.address == '0) && (req.length == cfg.device_size);

    // Page program chunk: stop at the page boundary
    assign room  = PAGE_SIZE - (state.cur_addr & PAGE_MASK);
    assign chunk = (state.bytes_left < room) ? state.bytes_left : room;

    // Erase step: whole block when aligned and enough remains, else a sector
    assign use_block  = ((state.cur_addr & blk_mask) == '0) &&
                        (state.bytes_left >= blk_size);
    assign erase_step = use_block ? blk_size : SECTOR_SIZE;
    assign step       = state.is_write ? chunk :
                        ((erase_step > state.bytes_left) ? state.bytes_left : erase_step);
    assign done       = (step == state.bytes_left);

    always_comb begin
        state_next      = state;
        rsp.status      = ST_OK;
        rsp.cmd_kind    = KIND_NONE;
        rsp.cmd_address = '0;
        rsp.cmd_bytes   = '0;
        rsp.last        = 1'b0;
        case (req.mode)
            MODE_ERASE, MODE_WRITE: begin
                // Drop any pending request and latch the new one if it passes
                state_next.active = 1'b0;
                if ((req.mode == MODE_ERASE) && misaligned) begin
                    rsp.status = ST_ALIGN;
                    rsp.last   = 1'b1;
                end else if (!in_range) begin
                    rsp.status = ST_RANGE;
                    rsp.last   = 1'b1;
                end else begin
                    state_next.is_write = (req.mode == MODE_WRITE);
                    state_next.cur_addr = {1'b0, req.address};
                    if ((req.mode == MODE_ERASE) && chip_erase) begin
                        state_next.bytes_left = '0;
                        state_next.active     = 1'b1;
                    end else begin
                        state_next.bytes_left = req.length;
                        state_next.active     = (req.length != '0);
                    end
                    rsp.last = !state_next.active;
                end
            end
            default: begin
                // Next command (mode three behaves the same)
                if (!state.active) begin
                    rsp.status = ST_IDLE;
                end else if (!state.is_write && (state.bytes_left == '0)) begin
                    rsp.cmd_kind      = KIND_CHIP;
                    rsp.last          = 1'b1;
                    state_next.active = 1'b0;
                end else begin
                    if (state.is_write) begin
                        rsp.cmd_kind  = KIND_PROG;
                        rsp.cmd_bytes = chunk[8:0];
                    end else begin
                        rsp.cmd_kind  = use_block ? KIND_BLOCK : KIND_SECTOR;
                    end
                    rsp.cmd_address       = state.cur_addr[23:0] & ADDR_MASK;
                    rsp.last              = done;
                    state_next.cur_addr   = state.cur_addr + step;
                    state_next.bytes_left = state.bytes_left - step;
                    if (done) begin
                        state_next.active = 1'b0;
                    end
                end
            end
        endcase
    end

endmodule

### sv/flash_command_planner.sv
// Flash command planner: splits erase and write requests into serial NOR commands.
// Each request passes through the input register and then the result register; m_valid
// rises once the result is loaded, and a result that is not taken holds back the input.
// Throughput: one request per cycle while results are taken; the plan state updates as a
// request leaves the input register, through one pass of compare, mask and add logic.
// Reset (aresetn low, synchronous): nothing pending, both stages empty, config at defaults.
module flash_command_planner #(
    parameter int unsigned PAGE_BYTES        = fcp_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES      = fcp_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES       = fcp_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned SMALL_BLOCK_BYTES = fcp_pkg::SMALL_BLOCK_BYTES_DEF,
    parameter int unsigned ADDR_BITS         = fcp_pkg::ADDR_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [24:0]    cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  fcp_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output fcp_pkg::rsp_t  m_data
);
    import fcp_pkg::*;

    cfg_t        cfg;
    req_t        req_reg;
    logic        req_valid_reg;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg;
    plan_state_t state_reg, state_next;
    logic        advance;

    fcp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fcp_step #(
        .PAGE_BYTES        (PAGE_BYTES),
        .SECTOR_BYTES      (SECTOR_BYTES),
        .BLOCK_BYTES       (BLOCK_BYTES),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
        .ADDR_BITS         (ADDR_BITS)
    ) u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .req        (req_reg),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    // Move a request forward when the result register is free or being drained
    assign advance = req_valid_reg && (!rsp_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // Plan state: advance once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (advance) begin
            rsp_valid_reg <= 1'b1;
        end else if (m_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = rsp_valid_reg;
    assign m_data  = rsp_reg;

    // A pending write always has bytes left to program
    a_write_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.active && state_reg.is_write |-> state_reg.bytes_left != '0)
        else $error("pending write with no bytes left");

    // Rejected requests always end the request
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_RANGE || m_data.status == ST_ALIGN)
        |-> m_data.last && m_data.cmd_kind == KIND_NONE)
        else $error("error result not marked last or carries a command");

    // Only page programs carry a byte count
    a_bytes_only_prog: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cmd_kind != KIND_PROG |-> m_data.cmd_bytes == '0)
        else $error("byte count on a non-program command");

    // A result that clears the pending state while planning must be flagged last
    a_done_clears_active: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && state_reg.active && req_reg.mode != MODE_ERASE &&
        req_reg.mode != MODE_WRITE && !state_next.active |-> rsp_next.last)
        else $error("request finished without last");

endmodule
